[hw/rtl/crdraw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crdraw_pkg;

   // Default screen geometry
   localparam int SCREEN_W_DEF       = 480;
   localparam int SCREEN_H_DEF       = 800;
   localparam int BYTES_PER_LINE_DEF = 100;

   // Coordinate fields on the bus and the internal signed width for clip sums
   localparam int FIELD_W = 12;
   localparam int COORD_W = 14;

   // Byte constants
   localparam logic [7:0] FULL_BYTE  = 8'hFF;
   localparam logic [7:0] EMPTY_BYTE = 8'h00;
   localparam logic [2:0] BIT_LAST   = 3'd7;

   // Command codes; the two codes above CMD_READ do nothing
   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_HLINE = 3'd1,
      CMD_VLINE = 3'd2,
      CMD_RECT  = 3'd3,
      CMD_FILL  = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   // Outline edges in drawing order
   localparam logic [1:0] SEG_TOP    = 2'd0;
   localparam logic [1:0] SEG_BOTTOM = 2'd1;
   localparam logic [1:0] SEG_LEFT   = 2'd2;
   localparam logic [1:0] SEG_RIGHT  = 2'd3;

   // Status from the byte step unit to the sequencer
   typedef struct packed {
      logic col_end;   // this byte holds the last row of the column span
      logic in_range;  // byte address lies inside the store
   } span_status_type;

   // Widen a signed bus coordinate to the internal width
   function automatic logic signed [COORD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
      return {{(COORD_W-FIELD_W){v[FIELD_W-1]}}, v};
   endfunction

endpackage

`default_nettype wire

[hw/rtl/crdraw_span.sv]
`timescale 1ns / 1ps
`default_nettype none

module crdraw_span #(
   parameter int RW       = 10,
   parameter int IW       = 16,
   parameter int FB_BYTES = 48000
) (
   input  wire logic [RW-1:0]               row_y,
   input  wire logic [RW-1:0]               row_end,
   input  wire logic [IW-1:0]               col_base,
   output logic [IW-1:0]                    byte_addr,
   output logic [7:0]                       bit_mask,
   output logic [RW-1:0]                    next_y,
   output crdraw_pkg::span_status_type      status
);

   logic [RW-1:0] last_blk;
   logic [RW-1:0] end_m1;
   logic [RW-1:0] last_row;
   logic          col_end;

   // Find the last row covered inside this byte
   always_comb begin
      last_blk = {row_y[RW-1:3], crdraw_pkg::BIT_LAST};
      end_m1   = row_end - RW'(1);
      col_end  = (last_blk >= end_m1);
      last_row = col_end ? end_m1 : last_blk;
      next_y   = last_row + RW'(1);
   end

   // Build the bit mask, MSB is the top row of the byte
   always_comb begin
      bit_mask = (crdraw_pkg::FULL_BYTE >> row_y[2:0])
               & (crdraw_pkg::FULL_BYTE << (crdraw_pkg::BIT_LAST - last_row[2:0]));
   end

   // Form the byte address and range check
   always_comb begin
      byte_addr       = col_base + IW'(row_y[RW-1:3]);
      status.col_end  = col_end;
      status.in_range = (byte_addr < IW'(FB_BYTES));
   end

endmodule

`default_nettype wire

[hw/rtl/crdraw_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module crdraw_mem #(
   parameter int DEPTH = 48000,
   parameter int AW    = 16
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/clipped_rect_draw_1bpp_rotated.sv]
`timescale 1ns / 1ps
`default_nettype none

// Drawing engine for a 1-bit-per-pixel framebuffer stored column-transposed and
// mirrored: portrait pixel (x, y) sits in byte (SCREEN_W-1-x)*BYTES_PER_LINE + y/8
// under mask 0x80 >> (y mod 8). Commands are clear, hline, vline, rectangle outline,
// filled rectangle and byte read; every primitive is clipped to the screen and each
// transaction returns one response (read_data is zero and is_read low for all but
// reads). The store is one single-port-write, single-port-read RAM, and its ports set
// the cost: a clear writes all SCREEN_W*BYTES_PER_LINE bytes (48000 by default) in
// turn, a draw sets up each line segment (four for an outline) and then reads each
// touched byte and merges and writes it back, a read issues one store read, and
// every command is accepted in idle and ends by handing its response to the output
// register, waiting while a stalled response still holds that register. The store holds
// garbage until the first clear. The engine takes the next command as soon as it is
// back in idle, while the previous response may still wait in the output register.
module clipped_rect_draw_1bpp_rotated #(
   parameter int SCREEN_W       = crdraw_pkg::SCREEN_W_DEF,
   parameter int SCREEN_H       = crdraw_pkg::SCREEN_H_DEF,
   parameter int BYTES_PER_LINE = crdraw_pkg::BYTES_PER_LINE_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pos_x[11:0], pos_y[23:12], width[35:24], height[47:36], color[48],
   // byte_address[64:49], zero[71:65]
   input  wire logic [71:0] req_tdata,
   // command[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]       rsp_tdata,
   // is_read
   output logic             rsp_tuser
);

   localparam int FB_BYTES = SCREEN_W * BYTES_PER_LINE;
   localparam int AW       = $clog2(FB_BYTES);
   localparam int IW       = $clog2(FB_BYTES + 256);
   localparam int CW       = $clog2(SCREEN_W + 1);
   localparam int RW       = $clog2(SCREEN_H + 1);
   localparam int CS       = crdraw_pkg::COORD_W;
   localparam int FW       = crdraw_pkg::FIELD_W;

   localparam logic signed [CS-1:0] W_S   = CS'(SCREEN_W);
   localparam logic signed [CS-1:0] H_S   = CS'(SCREEN_H);
   localparam logic signed [CS-1:0] ONE_S = CS'(1);
   localparam logic signed [CS-1:0] ZERO_S = CS'(0);
   localparam logic [IW-1:0]        BPL_I = IW'(BYTES_PER_LINE);
   localparam logic [AW-1:0]        CLR_LAST = AW'(FB_BYTES - 1);
   localparam logic [CW-1:0]        COL_MAX  = CW'(SCREEN_W - 1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CLEAR = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_STEP  = 7'b0001000,
      ST_MERGE = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // Control registers
   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   // Command payload
   logic [2:0]           cmd_ff, cmd_in;
   logic signed [CS-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic                 color_ff, color_in;
   logic [15:0]          baddr_ff, baddr_in;
   logic                 rok_ff, rok_in;

   // Walk state
   logic [1:0]    seg_ff, seg_in;
   logic [CW-1:0] cx_ff, cx_in, xe_ff, xe_in;
   logic [RW-1:0] cy_ff, cy_in, ys_ff, ys_in, ye_ff, ye_in;
   logic [IW-1:0] base_ff, base_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [7:0]    mask_ff, mask_in;
   logic          inr_ff, inr_in;
   logic          walk_end_ff, walk_end_in;
   logic [AW-1:0] clr_ff, clr_in;

   // Output register payload
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_user_ff, rsp_user_in;

   // Segment and clip signals
   logic signed [CS-1:0] seg_x, seg_y, seg_w, seg_h;
   logic signed [CS-1:0] x_end, y_end, xs_s, xe_s, ys_s, ye_s;
   logic                 seg_last, seg_hit;
   logic [IW-1:0]        col_rev, base_calc;

   // Memory ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   // Byte step unit
   logic [IW-1:0]                 span_addr;
   logic [7:0]                    span_mask;
   logic [RW-1:0]                 span_next_y;
   crdraw_pkg::span_status_type   span_status;

   logic req_fire;
   logic out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   crdraw_span #(
      .RW       (RW),
      .IW       (IW),
      .FB_BYTES (FB_BYTES)
   ) u_span (
      .row_y     (cy_ff),
      .row_end   (ye_ff),
      .col_base  (base_ff),
      .byte_addr (span_addr),
      .bit_mask  (span_mask),
      .next_y    (span_next_y),
      .status    (span_status)
   );

   crdraw_mem #(
      .DEPTH (FB_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pick the rectangle of the current segment; lines are one pixel thick
   always_comb begin
      seg_x = x_ff;
      seg_y = y_ff;
      seg_w = w_ff;
      seg_h = h_ff;
      unique case (cmd_ff)
         crdraw_pkg::CMD_HLINE: seg_h = ONE_S;
         crdraw_pkg::CMD_VLINE: seg_w = ONE_S;
         crdraw_pkg::CMD_RECT: begin
            unique case (seg_ff)
               crdraw_pkg::SEG_TOP: seg_h = ONE_S;
               crdraw_pkg::SEG_BOTTOM: begin
                  seg_y = y_ff + h_ff - ONE_S;
                  seg_h = ONE_S;
               end
               crdraw_pkg::SEG_LEFT: seg_w = ONE_S;
               crdraw_pkg::SEG_RIGHT: begin
                  seg_x = x_ff + w_ff - ONE_S;
                  seg_w = ONE_S;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      seg_last = (cmd_ff != crdraw_pkg::CMD_RECT) || (seg_ff == crdraw_pkg::SEG_RIGHT);
   end

   // Clip the segment to the screen
   always_comb begin
      x_end     = seg_x + seg_w;
      y_end     = seg_y + seg_h;
      xs_s      = (seg_x < ZERO_S) ? ZERO_S : seg_x;
      ys_s      = (seg_y < ZERO_S) ? ZERO_S : seg_y;
      xe_s      = (x_end > W_S) ? W_S : x_end;
      ye_s      = (y_end > H_S) ? H_S : y_end;
      seg_hit   = (xe_s > xs_s) && (ye_s > ys_s);
      col_rev   = IW'(COL_MAX - xs_s[CW-1:0]);
      base_calc = col_rev * BPL_I;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      color_in      = color_ff;
      baddr_in      = baddr_ff;
      rok_in        = rok_ff;
      seg_in        = seg_ff;
      cx_in         = cx_ff;
      xe_in         = xe_ff;
      cy_in         = cy_ff;
      ys_in         = ys_ff;
      ye_in         = ye_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      inr_in        = inr_ff;
      walk_end_in   = walk_end_ff;
      clr_in        = clr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = color_ff ? crdraw_pkg::FULL_BYTE : crdraw_pkg::EMPTY_BYTE;
      rd_en         = 1'b0;
      rd_addr       = span_addr[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tuser;
               x_in     = crdraw_pkg::sext_coord(req_tdata[FW-1:0]);
               y_in     = crdraw_pkg::sext_coord(req_tdata[2*FW-1:FW]);
               w_in     = crdraw_pkg::sext_coord(req_tdata[3*FW-1:2*FW]);
               h_in     = crdraw_pkg::sext_coord(req_tdata[4*FW-1:3*FW]);
               color_in = req_tdata[48];
               baddr_in = req_tdata[64:49];
               rok_in   = ({16'd0, req_tdata[64:49]} < 32'(FB_BYTES));
               seg_in   = crdraw_pkg::SEG_TOP;
               clr_in   = '0;
               unique case (req_tuser)
                  crdraw_pkg::CMD_CLEAR: state_in = ST_CLEAR;
                  crdraw_pkg::CMD_HLINE,
                  crdraw_pkg::CMD_VLINE,
                  crdraw_pkg::CMD_RECT,
                  crdraw_pkg::CMD_FILL:  state_in = ST_SETUP;
                  crdraw_pkg::CMD_READ:  state_in = ST_READ;
                  default:               state_in = ST_DONE;
               endcase
            end
         end

         // Sweep the whole store with the fill byte
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_DONE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end

         // Load the clipped bounds of one segment, or skip it
         ST_SETUP: begin
            if (seg_hit) begin
               cx_in    = xs_s[CW-1:0];
               xe_in    = xe_s[CW-1:0];
               cy_in    = ys_s[RW-1:0];
               ys_in    = ys_s[RW-1:0];
               ye_in    = ye_s[RW-1:0];
               base_in  = base_calc;
               state_in = ST_STEP;
            end else if (seg_last) begin
               state_in = ST_DONE;
            end else begin
               seg_in = seg_ff + 2'd1;
            end
         end

         // Fetch one byte and advance the cursor
         ST_STEP: begin
            rd_en       = 1'b1;
            addr_in     = span_addr;
            mask_in     = span_mask;
            inr_in      = span_status.in_range;
            walk_end_in = span_status.col_end && ((cx_ff + CW'(1)) == xe_ff);
            if (span_status.col_end) begin
               cx_in   = cx_ff + CW'(1);
               cy_in   = ys_ff;
               base_in = base_ff - BPL_I;
            end else begin
               cy_in = span_next_y;
            end
            state_in = ST_MERGE;
         end

         // Merge the mask into the fetched byte and write back
         ST_MERGE: begin
            wr_en   = inr_ff;
            wr_addr = addr_ff[AW-1:0];
            wr_data = color_ff ? (rd_data | mask_ff) : (rd_data & ~mask_ff);
            if (!walk_end_ff) begin
               state_in = ST_STEP;
            end else if (seg_last) begin
               state_in = ST_DONE;
            end else begin
               seg_in   = seg_ff + 2'd1;
               state_in = ST_SETUP;
            end
         end

         // Issue the store read for a byte read command
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = AW'(baddr_ff);
            state_in = ST_DONE;
         end

         // Hand the response to the output register
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_user_in   = (cmd_ff == crdraw_pkg::CMD_READ);
               rsp_data_in   = ((cmd_ff == crdraw_pkg::CMD_READ) && rok_ff) ?
                               rd_data : crdraw_pkg::EMPTY_BYTE;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      color_ff    <= color_in;
      baddr_ff    <= baddr_in;
      rok_ff      <= rok_in;
      seg_ff      <= seg_in;
      cx_ff       <= cx_in;
      xe_ff       <= xe_in;
      cy_ff       <= cy_in;
      ys_ff       <= ys_in;
      ye_ff       <= ye_in;
      base_ff     <= base_in;
      addr_ff     <= addr_in;
      mask_ff     <= mask_in;
      inr_ff      <= inr_in;
      walk_end_ff <= walk_end_in;
      clr_ff      <= clr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // The cursor stays inside the clipped span while walking
   a_cursor_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (cy_ff < ye_ff) && (cx_ff < xe_ff) && (ys_ff < ye_ff))
      else $error("walk cursor left the clipped span");

   // A merge always follows the fetch of its byte
   a_merge_after_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ($past(state_ff) == ST_STEP))
      else $error("merge without a preceding fetch");

   // The clear sweep ends right after the last byte
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && (clr_ff == CLR_LAST) |=> (state_ff == ST_DONE))
      else $error("clear sweep did not end at the last byte");

   // An accepted transaction takes the engine out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("engine stayed idle after accepting a transaction");

endmodule

`default_nettype wire

[tb/sv/draw_checker.sv]
`timescale 1ns / 1ps

// Watch both channels of the drawing engine, keep a shadow copy of the frame
// store and compare every response with the answer that its command predicts.
module draw_checker
   import crdraw_pkg::*;
#(
   parameter int SCREEN_W       = SCREEN_W_DEF,
   parameter int SCREEN_H       = SCREEN_H_DEF,
   parameter int BYTES_PER_LINE = BYTES_PER_LINE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // pos_x[11:0], pos_y[23:12], width[35:24], height[47:36], color[48],
   // byte_address[64:49], zero[71:65]
   input  logic [71:0] req_tdata,
   // command[2:0]
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   input  logic [7:0]  rsp_tdata,
   // is_read
   input  logic        rsp_tuser,
   output int          mismatches,
   output int          outstanding
);

   localparam int STORE_BYTES = SCREEN_W * BYTES_PER_LINE;

   typedef struct {
      logic [7:0] read_data;
      logic       is_read;
   } answer_type;

   logic [7:0] shadow_frame [STORE_BYTES];
   answer_type awaited_answers [$];
   int         fail_count = 0;

   assign mismatches = fail_count;

   // Count a failure and log it
   function automatic void report(string what);
      fail_count++;
      $display("%0t: %s", $time, what);
   endfunction

   // Set or clear rows [row_lo, row_hi) of one portrait column, byte by byte
   function automatic void paint_column(int col, int row_lo, int row_hi, bit ink);
      int         row;
      int         byte_i;
      int         stop;
      int         idx;
      logic [7:0] mask;
      row = row_lo;
      while (row < row_hi) begin
         byte_i = row / 8;
         stop   = byte_i * 8 + 7;
         if (stop > row_hi - 1) begin
            stop = row_hi - 1;
         end
         mask = (8'hFF >> (row & 7)) & (8'hFF << (7 - (stop & 7)));
         idx  = (SCREEN_W - 1 - col) * BYTES_PER_LINE + byte_i;
         // Drop pixels whose byte falls outside the store
         if (idx >= 0 && idx < STORE_BYTES) begin
            if (ink) begin
               shadow_frame[idx] = shadow_frame[idx] | mask;
            end else begin
               shadow_frame[idx] = shadow_frame[idx] & ~mask;
            end
         end
         row = stop + 1;
      end
   endfunction

   // Horizontal line, clipped to the screen
   function automatic void draw_across(int x, int y, int w, bit ink);
      if (y < 0 || y >= SCREEN_H || x >= SCREEN_W) begin
         return;
      end
      if (x < 0) begin
         w = w + x;
         x = 0;
      end
      if (x + w > SCREEN_W) begin
         w = SCREEN_W - x;
      end
      for (int i = 0; i < w; i++) begin
         paint_column(x + i, y, y + 1, ink);
      end
   endfunction

   // Vertical line, clipped to the screen
   function automatic void draw_down(int x, int y, int h, bit ink);
      if (x < 0 || x >= SCREEN_W || y >= SCREEN_H) begin
         return;
      end
      if (y < 0) begin
         h = h + y;
         y = 0;
      end
      if (y + h > SCREEN_H) begin
         h = SCREEN_H - y;
      end
      if (h <= 0) begin
         return;
      end
      paint_column(x, y, y + h, ink);
   endfunction

   // Filled rectangle: clip the low sides first, then the high sides
   function automatic void fill_block(int x, int y, int w, int h, bit ink);
      if (x < 0) begin
         w = w + x;
         x = 0;
      end
      if (y < 0) begin
         h = h + y;
         y = 0;
      end
      if (x + w > SCREEN_W) begin
         w = SCREEN_W - x;
      end
      if (y + h > SCREEN_H) begin
         h = SCREEN_H - y;
      end
      if (w <= 0 || h <= 0) begin
         return;
      end
      for (int i = 0; i < w; i++) begin
         paint_column(x + i, y, y + h, ink);
      end
   endfunction

   // Apply one command to the shadow store and return the answer it owes
   function automatic answer_type apply_command(logic [2:0] op, logic [71:0] payload);
      answer_type  ans;
      int          x;
      int          y;
      int          w;
      int          h;
      bit          ink;
      int unsigned addr;
      x    = $signed(payload[11:0]);
      y    = $signed(payload[23:12]);
      w    = $signed(payload[35:24]);
      h    = $signed(payload[47:36]);
      ink  = payload[48];
      addr = payload[64:49];
      ans.read_data = EMPTY_BYTE;
      ans.is_read   = 1'b0;
      case (op)
         CMD_CLEAR: begin
            foreach (shadow_frame[i]) begin
               shadow_frame[i] = ink ? FULL_BYTE : EMPTY_BYTE;
            end
         end
         CMD_HLINE: draw_across(x, y, w, ink);
         CMD_VLINE: draw_down(x, y, h, ink);
         CMD_RECT: begin
            // Top, bottom, left, right
            draw_across(x, y, w, ink);
            draw_across(x, y + h - 1, w, ink);
            draw_down(x, y, h, ink);
            draw_down(x + w - 1, y, h, ink);
         end
         CMD_FILL: fill_block(x, y, w, h, ink);
         CMD_READ: begin
            ans.is_read = 1'b1;
            if (addr < STORE_BYTES) begin
               ans.read_data = shadow_frame[addr];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // Predict on each request transaction, check on each response transaction
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         awaited_answers.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_answers.push_back(apply_command(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               report($sformatf({"expected no response, got read_data %02h",
                                 " is_read %0b"}, rsp_tdata, rsp_tuser));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_tdata !== want.read_data) begin
                  report($sformatf("read_data expected %02h, got %02h",
                                   want.read_data, rsp_tdata));
               end
               if (rsp_tuser !== want.is_read) begin
                  report($sformatf("is_read expected %0b, got %0b",
                                   want.is_read, rsp_tuser));
               end
            end
         end
      end
      outstanding <= awaited_answers.size();
   end

endmodule

[tb/sv/tb_clipped_rect_draw_1bpp_rotated.sv]
`timescale 1ns / 1ps

module tb_clipped_rect_draw_1bpp_rotated;
   import crdraw_pkg::*;

   localparam int SCREEN_W       = SCREEN_W_DEF;
   localparam int SCREEN_H       = SCREEN_H_DEF;
   localparam int BYTES_PER_LINE = BYTES_PER_LINE_DEF;

   // The two command codes the engine must ignore
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam int ITEMS_PER_PHASE = 480;

   // Slowest single command is a full-screen fill, which reads and writes back every
   // byte, plus response stalls. QUIET_LIMIT allows well over that with no transaction.
   localparam int QUIET_LIMIT = 500000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = CMD_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;

   int mismatches;
   int outstanding;
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int idle_by_phase[4]  = '{0, 57, 0, 31};
   int stall_by_phase[4] = '{0, 0, 57, 31};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   clipped_rect_draw_1bpp_rotated dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   draw_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Stall the response side at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Abort when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > QUIET_LIMIT) begin
         $display("[clipped_rect_draw_1bpp_rotated] ERROR");
         $finish;
      end
   end

   // Offer one command, with random idle cycles first; return once accepted
   task automatic send(logic [2:0] op, int x, int y, int w, int h, bit ink, int addr);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {7'd0, addr[15:0], ink, h[11:0], w[11:0], y[11:0], x[11:0]};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // Hold the sender until every expected response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   // Coordinate near either screen border, anywhere on it, or anywhere at all
   function automatic int near_border(int span);
      case ($urandom_range(9))
         0, 1, 2, 3: return int'($urandom_range(24)) - 8;
         4, 5, 6, 7: return span - 17 + int'($urandom_range(24));
         8:          return int'($urandom_range(span - 1));
         default:    return int'($urandom_range(4095)) - 2048;
      endcase
   endfunction

   // Mostly short lengths, zero and negative among them; full range if allowed
   function automatic int pick_length(bit allow_full);
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: return int'($urandom_range(22)) - 2;
         7, 8:                return int'($urandom_range(64));
         default: begin
            if (allow_full) begin
               return int'($urandom_range(4095)) - 2048;
            end
            return int'($urandom_range(120));
         end
      endcase
   endfunction

   function automatic int on_screen(int span);
      case ($urandom_range(2))
         0:       return int'($urandom_range(24));
         1:       return span - 1 - int'($urandom_range(24));
         default: return int'($urandom_range(span - 1));
      endcase
   endfunction

   // Byte address of a pixel where drawing happens, or any 16-bit address
   function automatic int read_address();
      int px;
      int py;
      if ($urandom_range(7) == 0) begin
         return int'($urandom_range(16'hFFFF));
      end
      px = on_screen(SCREEN_W);
      py = on_screen(SCREEN_H);
      return (SCREEN_W - 1 - px) * BYTES_PER_LINE + py / 8;
   endfunction

   task automatic send_random();
      int         pick;
      int         x;
      int         y;
      int         w;
      int         h;
      bit         ink;
      int         addr;
      logic [2:0] op;
      pick = $urandom_range(99);
      x    = near_border(SCREEN_W);
      y    = near_border(SCREEN_H);
      w    = pick_length(1'b1);
      h    = pick_length(1'b1);
      ink  = $urandom_range(1);
      addr = $urandom_range(16'hFFFF);
      if (pick < 36) begin
         op   = CMD_READ;
         addr = read_address();
      end else if (pick < 51) begin
         op = CMD_HLINE;
      end else if (pick < 66) begin
         op = CMD_VLINE;
      end else if (pick < 81) begin
         op = CMD_RECT;
      end else if (pick < 96) begin
         // Keep fills small; large ones are slow
         op = CMD_FILL;
         w  = pick_length($urandom_range(19) == 0);
         h  = pick_length($urandom_range(19) == 0);
      end else begin
         op = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
      end
      send(op, x, y, w, h, ink, addr);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Clear both ways, then clipping corners, degenerate sizes, spare codes and reads
      send(CMD_CLEAR, 0, 0, 0, 0, 1'b1, 0);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, 0);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, SCREEN_W * BYTES_PER_LINE - 1);
      send(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 0);
      send(CMD_HLINE, -5, 0, 20, 0, 1'b1, 0);
      send(CMD_HLINE, 470, SCREEN_H - 1, 50, 0, 1'b1, 0);
      send(CMD_HLINE, SCREEN_W, 5, 10, 0, 1'b1, 0);
      send(CMD_HLINE, 2047, -2048, 2047, 2047, 1'b1, 16'hFFFF);
      send(CMD_HLINE, 2, 9, -2048, 0, 1'b1, 0);
      send(CMD_VLINE, 0, -10, 0, 30, 1'b1, 0);
      send(CMD_VLINE, SCREEN_W - 1, 790, 0, 100, 1'b1, 0);
      send(CMD_VLINE, 3, 3, 0, 0, 1'b1, 0);
      send(CMD_VLINE, 4, 3, 0, -2048, 1'b1, 0);
      send(CMD_RECT, -3, -3, 10, 12, 1'b1, 0);
      send(CMD_RECT, 20, 20, 1, 1, 1'b1, 0);
      send(CMD_RECT, 16, 30, 0, 5, 1'b1, 0);
      send(CMD_FILL, 8, 3, 5, 13, 1'b1, 0);
      send(CMD_FILL, 470, 795, 2047, 2047, 1'b1, 0);
      send(CMD_FILL, -2048, -2048, 2047, 2047, 1'b1, 0);
      send(CMD_FILL, 9, 5, 2, 4, 1'b0, 0);
      send(CMD_SPARE_A, 1, 1, 4, 4, 1'b1, 0);
      send(CMD_SPARE_B, 2, 2, 4, 4, 1'b1, 0);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, (SCREEN_W - 1 - 8) * BYTES_PER_LINE);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, (SCREEN_W - 1) * BYTES_PER_LINE);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, BYTES_PER_LINE - 1);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, SCREEN_W * BYTES_PER_LINE);
      send(CMD_READ, 0, 0, 0, 0, 1'b0, 16'hFFFF);

      // Random phases, each starting from an idle engine and a fresh clear
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         drain();
         send(CMD_CLEAR, near_border(SCREEN_W), near_border(SCREEN_H),
              pick_length(1'b1), pick_length(1'b1), $urandom_range(1),
              $urandom_range(16'hFFFF));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_random();
         end
      end

      // Let the last responses come back, then a short tail for strays
      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("[clipped_rect_draw_1bpp_rotated] OK");
      end else begin
         $display("[clipped_rect_draw_1bpp_rotated] ERROR");
      end
      $finish;
   end

endmodule
